// ===== rtl/websocket_client_frame_encoder_top_defines.svh =====
// assertion macros for the websocket client frame encoder
// used by websocket_client_frame_encoder_top; expects clk and arst_n in scope
`ifndef WEBSOCKET_CLIENT_FRAME_ENCODER_TOP_DEFINES_SVH
`define WEBSOCKET_CLIENT_FRAME_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTH

// checked only out of reset
`define WSE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("wsenc check failed");

// checked at every edge, reset included
`define WSE_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("wsenc check failed");

`else

`define WSE_ASSERT(lbl, prop)
`define WSE_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/wsenc_pkg.sv =====
// types and constants of the websocket client frame encoder
// no dependencies
`timescale 1ns / 1ps

package wsenc_pkg;

	typedef enum logic [0:0] {
		MODE_START   = 1'b0,
		MODE_PAYLOAD = 1'b1
	} mode_t;

	typedef logic [7:0] byte_t;

	localparam int unsigned LEN_W  = 63;
	localparam int unsigned MASK_W = 32;

	// first header byte: fin set, text opcode
	localparam byte_t FIN_TEXT = 8'h81;
	// mask bit of the second header byte
	localparam byte_t MASK_BIT = 8'h80;
	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [LEN_W-1:0] LEN_MAX_SHORT = 63'd125;
	localparam logic [LEN_W-1:0] LEN_MAX_16    = 63'd65535;

	// header bytes that follow the first one
	localparam int unsigned HDR_TAIL_MAX   = 13;
	localparam logic [3:0]  HDR_TAIL_SHORT = 4'd5;
	localparam logic [3:0]  HDR_TAIL_16    = 4'd7;
	localparam logic [3:0]  HDR_TAIL_64    = 4'd13;

endpackage

// ===== rtl/websocket_client_frame_encoder_top.sv =====
// websocket client frame encoder, single module
// depends on wsenc_pkg and websocket_client_frame_encoder_top_defines.svh
`timescale 1ns / 1ps
`include "websocket_client_frame_encoder_top_defines.svh"

// Use of the block
// s_axis: input items. tuser selects the kind: start (0) or payload (1).
//   a start transfer carries length and mask key and opens a fresh frame,
//   abandoning any frame still open. a payload transfer carries one byte;
//   with no frame open it is taken and dropped.
// m_axis: encoded frame bytes, one per transfer. tuser marks header and
//   mask bytes, tlast the final byte of a frame.
// output: the first output byte of an input transfer is registered and
//   sits in the output register until the receiver takes it.
// throughput: with m_axis_tready high, payload items run at one per cycle.
//   a start item gives a header burst of 6, 8 or 14 bytes (7-bit, 16-bit or
//   64-bit length form); the bytes after the first drain one per cycle, as
//   m_axis_tready allows, from a header shift register; s_axis_tready is low meanwhile.
// stalls: when m_axis_tready is low with a byte waiting, the output
//   register holds and s_axis_tready drops in the same cycle; nothing is
//   lost and nothing is repeated.
// reset: arst_n clears the output valid, the burst count and the frame
//   state, so no frame is open and no byte is pending.
module websocket_client_frame_encoder_top
	import wsenc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,

	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [62:0] payload_length, [94:63] mask_key, [102:95] data_byte, [103] zero
	input  logic [103:0] s_axis_tdata,
	// [0] mode
	input  logic [0:0]   s_axis_tuser,

	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [7:0] out_byte
	output logic [7:0]   m_axis_tdata,
	// [0] is_header
	output logic [0:0]   m_axis_tuser,
	// frame_last
	output logic         m_axis_tlast
);

	// input fields
	mode_t             in_mode;
	logic [LEN_W-1:0]  in_len;
	logic [MASK_W-1:0] in_key;
	byte_t             in_data;

	assign in_mode = mode_t'(s_axis_tuser);
	assign in_len  = s_axis_tdata[62:0];
	assign in_key  = s_axis_tdata[94:63];
	assign in_data = s_axis_tdata[102:95];

	// frame state
	logic [LEN_W-1:0]  bytes_remaining_q;
	logic [MASK_W-1:0] held_mask_q;
	logic [1:0]        mask_phase_q;
	logic              frame_open_q;

	// header burst: bytes after the first one, shifted out from entry 0
	byte_t             hdr_buf_q [HDR_TAIL_MAX];
	logic [3:0]        hdr_cnt_q;
	logic              hdr_zero_q;   // empty frame, last mask byte ends it

	// output register
	logic              out_valid_q;
	byte_t             out_byte_q;
	logic              out_hdr_q;
	logic              out_last_q;

	logic              out_load;
	logic              in_fire;
	logic              hdr_busy;

	byte_t             hdr_new [HDR_TAIL_MAX];
	logic [3:0]        hdr_new_cnt;
	byte_t             key_byte;
	logic              pay_last;

	assign hdr_busy      = (hdr_cnt_q != 4'd0);
	assign out_load      = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !hdr_busy && out_load;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// header tail for a start item, length form picked by compare
	always_comb begin
		for (int i = 0; i < HDR_TAIL_MAX; i++) begin
			hdr_new[i] = '0;
		end
		if (in_len <= LEN_MAX_SHORT) begin
			hdr_new[0]  = MASK_BIT | {1'b0, in_len[6:0]};
			hdr_new[1]  = in_key[31:24];
			hdr_new[2]  = in_key[23:16];
			hdr_new[3]  = in_key[15:8];
			hdr_new[4]  = in_key[7:0];
			hdr_new_cnt = HDR_TAIL_SHORT;
		end else if (in_len <= LEN_MAX_16) begin
			hdr_new[0]  = MASK_BIT | {1'b0, LEN_CODE_16};
			hdr_new[1]  = in_len[15:8];
			hdr_new[2]  = in_len[7:0];
			hdr_new[3]  = in_key[31:24];
			hdr_new[4]  = in_key[23:16];
			hdr_new[5]  = in_key[15:8];
			hdr_new[6]  = in_key[7:0];
			hdr_new_cnt = HDR_TAIL_16;
		end else begin
			hdr_new[0]  = MASK_BIT | {1'b0, LEN_CODE_64};
			// 64-bit length, top bit always zero
			hdr_new[1]  = {1'b0, in_len[62:56]};
			hdr_new[2]  = in_len[55:48];
			hdr_new[3]  = in_len[47:40];
			hdr_new[4]  = in_len[39:32];
			hdr_new[5]  = in_len[31:24];
			hdr_new[6]  = in_len[23:16];
			hdr_new[7]  = in_len[15:8];
			hdr_new[8]  = in_len[7:0];
			hdr_new[9]  = in_key[31:24];
			hdr_new[10] = in_key[23:16];
			hdr_new[11] = in_key[15:8];
			hdr_new[12] = in_key[7:0];
			hdr_new_cnt = HDR_TAIL_64;
		end
	end

	// mask byte for the next payload position, first key byte on top
	always_comb begin
		unique case (mask_phase_q)
			2'd0:    key_byte = held_mask_q[31:24];
			2'd1:    key_byte = held_mask_q[23:16];
			2'd2:    key_byte = held_mask_q[15:8];
			default: key_byte = held_mask_q[7:0];
		endcase
	end

	// an open frame always has at least one byte to go
	assign pay_last = (bytes_remaining_q == 63'd1);

	// frame state and burst control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q       <= 1'b0;
			hdr_cnt_q         <= 4'd0;
			hdr_zero_q        <= 1'b0;
			frame_open_q      <= 1'b0;
			bytes_remaining_q <= '0;
			held_mask_q       <= '0;
			mask_phase_q      <= 2'd0;
		end else begin
			priority if (hdr_busy && out_load) begin
				out_valid_q <= 1'b1;
				hdr_cnt_q   <= hdr_cnt_q - 4'd1;
			end else if (in_fire && in_mode == MODE_START) begin
				out_valid_q       <= 1'b1;
				hdr_cnt_q         <= hdr_new_cnt;
				hdr_zero_q        <= (in_len == '0);
				held_mask_q       <= in_key;
				mask_phase_q      <= 2'd0;
				bytes_remaining_q <= in_len;
				frame_open_q      <= (in_len != '0);
			end else if (in_fire && frame_open_q) begin
				out_valid_q       <= 1'b1;
				bytes_remaining_q <= bytes_remaining_q - 63'd1;
				mask_phase_q      <= mask_phase_q + 2'd1;
				if (pay_last) begin
					frame_open_q <= 1'b0;
				end
			end else if (out_load) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload and header shift register, no reset needed
	always_ff @(posedge clk) begin
		priority if (hdr_busy && out_load) begin
			out_byte_q <= hdr_buf_q[0];
			out_hdr_q  <= 1'b1;
			out_last_q <= (hdr_cnt_q == 4'd1) && hdr_zero_q;
			for (int i = 0; i < HDR_TAIL_MAX - 1; i++) begin
				hdr_buf_q[i] <= hdr_buf_q[i+1];
			end
		end else if (in_fire && in_mode == MODE_START) begin
			out_byte_q <= FIN_TEXT;
			out_hdr_q  <= 1'b1;
			out_last_q <= 1'b0;
			for (int i = 0; i < HDR_TAIL_MAX; i++) begin
				hdr_buf_q[i] <= hdr_new[i];
			end
		end else if (in_fire && frame_open_q) begin
			out_byte_q <= in_data ^ key_byte;
			out_hdr_q  <= 1'b0;
			out_last_q <= pay_last;
		end else begin
			out_byte_q <= out_byte_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_hdr_q;
	assign m_axis_tlast  = out_last_q;

	// no input is taken while a header burst drains
	`WSE_ASSERT_ALWAYS(a_no_take_in_burst, hdr_busy |-> !s_axis_tready)

	// a start transfer puts the fin/text byte in the output register next
	`WSE_ASSERT(a_start_first_byte, (in_fire && in_mode == MODE_START) |=> (m_axis_tvalid && m_axis_tdata == FIN_TEXT && m_axis_tuser[0]))

	// a frame only opens through a start transfer
	`WSE_ASSERT(a_open_by_start, $rose(frame_open_q) |-> $past(in_fire && in_mode == MODE_START))

endmodule
